@@ rtl/rc5_block_cipher_core_assert.svh @@
// Assertion macros shared by the cipher RTL.
// No dependencies; take in with a plain include.
`ifndef RC5_BLOCK_CIPHER_CORE_ASSERT_SVH
`define RC5_BLOCK_CIPHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RC5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define RC5_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rc5_pkg.sv @@
// Package for the RC5 core: word type, magic constants, mode, register and
// unit operation codes, rotate helpers. No dependencies.
package rc5_pkg;

  localparam int WORD_BITS  = 32;
  localparam int SH_W       = $clog2(WORD_BITS);
  localparam int WORD_BYTES = WORD_BITS / 8;
  localparam int BPOS_W     = $clog2(WORD_BYTES);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [SH_W-1:0]      shamt_t;

  localparam word_t MAGIC_P = 32'hb7e15163;
  localparam word_t MAGIC_Q = 32'h9e3779b9;

  // Input item kinds (carried in tuser)
  localparam logic [1:0] MODE_KEY = 2'd0;
  localparam logic [1:0] MODE_ENC = 2'd1;
  localparam logic [1:0] MODE_DEC = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_ROUND_COUNT = 1'b0;
  localparam logic [0:0] REG_KEY_LENGTH  = 1'b1;

  // Shared round unit operations
  typedef logic [2:0] ru_op_t;
  localparam ru_op_t RU_ADD  = 3'd0;  // x + z
  localparam ru_op_t RU_SUB  = 3'd1;  // x - z
  localparam ru_op_t RU_ENC  = 3'd2;  // rotl(x ^ y, y) + z
  localparam ru_op_t RU_DEC  = 3'd3;  // rotr(x - z, y) ^ y
  localparam ru_op_t RU_MIX3 = 3'd4;  // rotl(x + y + z, 3)
  localparam ru_op_t RU_MIXV = 3'd5;  // rotl(x + y + z, y + z)

  function automatic word_t rotl(input word_t x, input shamt_t n);
    logic [2*WORD_BITS-1:0] dbl;
    dbl = {x, x} << n;
    return dbl[2*WORD_BITS-1:WORD_BITS];
  endfunction

  function automatic word_t rotr(input word_t x, input shamt_t n);
    logic [2*WORD_BITS-1:0] dbl;
    dbl = {x, x} >> n;
    return dbl[WORD_BITS-1:0];
  endfunction

endpackage

@@ rtl/rc5_round_unit.sv @@
// Shared arithmetic unit of the RC5 core: add, subtract, half-rounds and
// key-mixing steps on one word. Depends on rc5_pkg.
module rc5_round_unit import rc5_pkg::*; (
  input  ru_op_t op,
  input  word_t  x,
  input  word_t  y,
  input  word_t  z,
  output word_t  res
);

  word_t yz_sum;
  word_t xyz_sum;

  assign yz_sum  = y + z;
  assign xyz_sum = x + yz_sum;

  // Select the operation
  always_comb begin
    case (op)
      RU_ADD:  res = x + z;
      RU_SUB:  res = x - z;
      RU_ENC:  res = rotl(x ^ y, y[SH_W-1:0]) + z;
      RU_DEC:  res = rotr(x - z, y[SH_W-1:0]) ^ y;
      RU_MIX3: res = rotl(xyz_sum, shamt_t'(3));
      RU_MIXV: res = rotl(xyz_sum, yz_sum[SH_W-1:0]);
      default: res = x;
    endcase
  end

endmodule

@@ rtl/rc5_block_cipher_core.sv @@
// RC5-32 cipher core: key loading, key expansion and block encrypt/decrypt
// through one shared round unit. Depends on rc5_pkg, rc5_round_unit and the
// assertion macro header.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+---------------------------------------
//  in_      | in  | in_tvalid/tready   | tuser: mode; tdata: key_byte, a, b
//  out_     | out | out_tvalid/tready  | tuser: status; tdata: out_a, out_b
//  cfg_     | in  | cfg_we             | cfg_index, cfg_data
//
// Key bytes are accepted back to back in ST_IDLE. The last key byte starts
// expansion: a seed pass over t table entries, then 3*max(t, c) mixing steps,
// each through ST_MIX_RD, ST_MIX_A and ST_MIX_B (t = 2r+2, c key words).
// Block: ST_BLK runs one half-round per cycle, limited by one round-key read
// per cycle, then ST_OUT. A block without a key goes to ST_OUT with status set.
// Synchronous active-low reset clears control state; no clearing pass.
// A result waiting in the output register does not block the next accept;
// a finished block then waits in ST_OUT, with in_tready low, until it frees.
`include "rc5_block_cipher_core_assert.svh"

module rc5_block_cipher_core import rc5_pkg::*; #(
  parameter int MAX_ROUNDS    = 255,
  parameter int MAX_KEY_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // cfg write port
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [7:0] key_byte, [39:8] word_a, [71:40] word_b
  input  logic [1:0]  in_tuser,   // [1:0] mode
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] out_a, [63:32] out_b
  output logic [0:0]  out_tuser   // [0] status
);

  localparam int TABLE_DEPTH = 2 * (MAX_ROUNDS + 1);
  localparam int TW          = $clog2(TABLE_DEPTH);
  localparam int KW_DEPTH    = (MAX_KEY_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int KW_AW       = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
  localparam int N_MAX       = 3 * ((TABLE_DEPTH > KW_DEPTH) ? TABLE_DEPTH : KW_DEPTH);
  localparam int N_W         = $clog2(N_MAX + 1);
  localparam int RC_W        = 8;
  localparam int KL_W        = 9;
  localparam logic [RC_W-1:0] RC_MAX   = RC_W'(MAX_ROUNDS);
  localparam logic [RC_W-1:0] RC_RESET = (MAX_ROUNDS < 12) ? RC_W'(MAX_ROUNDS) : RC_W'(12);
  localparam logic [KL_W-1:0] KL_MAX   = KL_W'(MAX_KEY_BYTES);
  localparam logic [KL_W-1:0] KL_RESET = KL_W'(16);

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_MIX_RD = 3'd2;
  localparam logic [2:0] ST_MIX_A  = 3'd3;
  localparam logic [2:0] ST_MIX_B  = 3'd4;
  localparam logic [2:0] ST_BLK    = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // Unpack input payload
  logic [1:0] in_mode;
  logic [7:0] in_key_byte;
  word_t      in_word_a;
  word_t      in_word_b;
  assign in_mode     = in_tuser;
  assign in_key_byte = in_tdata[7:0];
  assign in_word_a   = in_tdata[39:8];
  assign in_word_b   = in_tdata[71:40];

  // Registers
  logic [2:0]      state_r,     state_nxt;
  logic [RC_W-1:0] round_cnt_r, round_cnt_nxt;
  logic [KL_W-1:0] key_len_r,   key_len_nxt;
  logic [KL_W-1:0] seen_r,      seen_nxt;
  logic            key_valid_r, key_valid_nxt;
  word_t           a_r,         a_nxt;
  word_t           b_r,         b_nxt;
  word_t           seed_r,      seed_nxt;
  word_t           asm_r,       asm_nxt;
  logic            dec_r,       dec_nxt;
  logic            status_r,    status_nxt;
  logic [TW-1:0]   i_r,         i_nxt;
  logic [KW_AW-1:0] j_r,        j_nxt;
  logic [N_W-1:0]  k_r,         k_nxt;
  logic            out_valid_r, out_valid_nxt;
  word_t           out_a_r,     out_a_nxt;
  word_t           out_b_r,     out_b_nxt;
  logic            out_st_r,    out_st_nxt;

  // Memories
  word_t rk_mem [TABLE_DEPTH];
  word_t kw_mem [KW_DEPTH];
  word_t rk_rdata_r;
  word_t kw_rdata_r;
  logic            rk_we;
  logic [TW-1:0]   rk_waddr;
  logic [TW-1:0]   rk_raddr;
  word_t           rk_wdata;
  logic            kw_we;
  logic [KW_AW-1:0] kw_waddr;
  word_t           kw_wdata;

  // Shared unit
  ru_op_t ru_op;
  word_t  ru_x, ru_y, ru_z, ru_res;

  rc5_round_unit u_round (
    .op  (ru_op),
    .x   (ru_x),
    .y   (ru_y),
    .z   (ru_z),
    .res (ru_res)
  );

  // Derived key schedule limits
  logic [KL_W-1:0]  eff_len;
  logic [KL_W-1:0]  seen_inc;
  logic [KW_AW-1:0] c_last;
  logic [TW-1:0]    rk_last;
  logic [N_W-1:0]   t_cnt, c_cnt, big_cnt, n_last;
  logic             accept;
  logic             out_free;
  logic             blk_last;
  logic             blk_first_pair;
  logic             mix_last;
  logic [BPOS_W-1:0] byte_pos;

  assign eff_len  = (key_len_r == '0) ? KL_W'(1) :
                    ((key_len_r > KL_MAX) ? KL_MAX : key_len_r);
  assign seen_inc = seen_r + KL_W'(1);
  assign c_last   = KW_AW'((eff_len - KL_W'(1)) >> BPOS_W);
  assign rk_last  = TW'({round_cnt_r, 1'b1});
  assign t_cnt    = N_W'({round_cnt_r, 1'b0}) + N_W'(2);
  assign c_cnt    = N_W'(c_last) + N_W'(1);
  assign big_cnt  = (t_cnt > c_cnt) ? t_cnt : c_cnt;
  assign n_last   = big_cnt + (big_cnt << 1) - N_W'(1);
  assign mix_last = (k_r == n_last);
  assign byte_pos = seen_r[BPOS_W-1:0];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign blk_first_pair = (i_r[TW-1:1] == '0);
  assign blk_last       = dec_r ? (i_r == '0) : (i_r == rk_last);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    round_cnt_nxt = round_cnt_r;
    key_len_nxt   = key_len_r;
    seen_nxt      = seen_r;
    key_valid_nxt = key_valid_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    seed_nxt      = seed_r;
    asm_nxt       = asm_r;
    dec_nxt       = dec_r;
    status_nxt    = status_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_st_nxt    = out_st_r;

    rk_we    = 1'b0;
    rk_waddr = i_r;
    rk_wdata = ru_res;
    rk_raddr = i_r;
    kw_we    = 1'b0;
    kw_waddr = j_r;
    kw_wdata = ru_res;

    ru_op = RU_ADD;
    ru_x  = seed_r;
    ru_y  = a_r;
    ru_z  = MAGIC_Q;

    // Configuration writes; the user must issue them only while no transaction is in flight (not enforced here)
    if (cfg_we) begin
      case (cfg_index)
        REG_ROUND_COUNT: begin
          round_cnt_nxt = (cfg_data[RC_W-1:0] > RC_MAX) ? RC_MAX : cfg_data[RC_W-1:0];
          key_valid_nxt = 1'b0;
        end
        REG_KEY_LENGTH: begin
          key_len_nxt = cfg_data;
          seen_nxt    = '0;
        end
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        rk_raddr = (in_mode == MODE_DEC) ? rk_last : '0;
        if (accept) begin
          case (in_mode)
            MODE_KEY: begin
              // Pack the byte little-endian and store the partial word
              asm_nxt = (byte_pos == '0) ? word_t'(in_key_byte) :
                        (asm_r | (word_t'(in_key_byte) << {byte_pos, 3'b000}));
              kw_we    = 1'b1;
              kw_waddr = KW_AW'(seen_r >> BPOS_W);
              kw_wdata = asm_nxt;
              seen_nxt = seen_inc;
              if (seen_inc >= eff_len) begin
                i_nxt     = '0;
                seed_nxt  = MAGIC_P;
                state_nxt = ST_SEED;
              end
            end
            MODE_ENC, MODE_DEC: begin
              dec_nxt = (in_mode == MODE_DEC);
              if (key_valid_r) begin
                a_nxt     = in_word_a;
                b_nxt     = in_word_b;
                i_nxt     = (in_mode == MODE_DEC) ? rk_last : '0;
                state_nxt = ST_BLK;
              end else begin
                a_nxt      = '0;
                b_nxt      = '0;
                status_nxt = 1'b1;
                state_nxt  = ST_OUT;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SEED: begin
        // Fill the table with P + k*Q
        rk_we    = 1'b1;
        rk_wdata = seed_r;
        seed_nxt = ru_res;
        if (i_r == rk_last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          a_nxt     = '0;
          b_nxt     = '0;
          state_nxt = ST_MIX_RD;
        end else begin
          i_nxt = i_r + TW'(1);
        end
      end

      ST_MIX_RD: begin
        // Issue table and key word reads
        state_nxt = ST_MIX_A;
      end

      ST_MIX_A: begin
        ru_op     = RU_MIX3;
        ru_x      = rk_rdata_r;
        ru_y      = a_r;
        ru_z      = b_r;
        a_nxt     = ru_res;
        rk_we     = 1'b1;
        state_nxt = ST_MIX_B;
      end

      ST_MIX_B: begin
        ru_op = RU_MIXV;
        ru_x  = kw_rdata_r;
        ru_y  = a_r;
        ru_z  = b_r;
        b_nxt = ru_res;
        kw_we = 1'b1;
        i_nxt = (i_r == rk_last) ? '0 : i_r + TW'(1);
        j_nxt = (j_r == c_last) ? '0 : j_r + KW_AW'(1);
        k_nxt = k_r + N_W'(1);
        if (mix_last) begin
          key_valid_nxt = 1'b1;
          seen_nxt      = '0;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_MIX_RD;
        end
      end

      ST_BLK: begin
        // One half-round per cycle; even table index updates a, odd updates b
        ru_x  = i_r[0] ? b_r : a_r;
        ru_y  = i_r[0] ? a_r : b_r;
        ru_z  = rk_rdata_r;
        ru_op = dec_r ? (blk_first_pair ? RU_SUB : RU_DEC) :
                        (blk_first_pair ? RU_ADD : RU_ENC);
        if (i_r[0]) b_nxt = ru_res;
        else        a_nxt = ru_res;
        i_nxt    = dec_r ? i_r - TW'(1) : i_r + TW'(1);
        rk_raddr = i_nxt;
        if (blk_last) begin
          status_nxt = 1'b0;
          state_nxt  = ST_OUT;
        end
      end

      ST_OUT: begin
        // Hand the result to the output register once it frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = a_r;
          out_b_nxt     = b_r;
          out_st_nxt    = status_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_cnt_r <= RC_RESET;
      key_len_r   <= KL_RESET;
      seen_r      <= '0;
      key_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      round_cnt_r <= round_cnt_nxt;
      key_len_r   <= key_len_nxt;
      seen_r      <= seen_nxt;
      key_valid_r <= key_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    seed_r   <= seed_nxt;
    asm_r    <= asm_nxt;
    dec_r    <= dec_nxt;
    status_r <= status_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    out_a_r  <= out_a_nxt;
    out_b_r  <= out_b_nxt;
    out_st_r <= out_st_nxt;
  end

  // Round-key table
  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_rdata_r <= rk_mem[rk_raddr];
  end

  // Key word store
  always_ff @(posedge clk) begin
    if (kw_we) kw_mem[kw_waddr] <= kw_wdata;
    kw_rdata_r <= kw_mem[j_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_b_r, out_a_r};
  assign out_tuser  = out_st_r;

  `RC5_ASSERT_IMP(a_nokey_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == '0, "status set with nonzero result")
  `RC5_ASSERT_IMP(a_blk_key, clk, rst_n, state_r == ST_BLK, key_valid_r, "block round without expanded key")
  `RC5_ASSERT_IMP(a_blk_idx, clk, rst_n, state_r == ST_BLK, i_r <= rk_last, "round key index past table end")
  `RC5_ASSERT_IMP(a_mix_j, clk, rst_n, state_r == ST_MIX_A || state_r == ST_MIX_B, j_r <= c_last, "key word index past key end")
  `RC5_ASSERT_NXT(a_exp_done, clk, rst_n, state_r == ST_MIX_B && mix_last, key_valid_r && seen_r == '0, "expansion end did not arm key")

endmodule
